@@ rtl/core/lstra_pkg.sv @@
// shared types, constants and a saturating add helper for the lazy segment tree
// no dependencies; imported by every module of the block except lstra_ram
package lstra_pkg;

    // tree size and derived widths
    localparam int LEAVES  = 1024;
    localparam int SLOTS   = 2 * LEAVES;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int POS_W   = 11;
    localparam int SPAN_W  = POS_W;
    localparam int ADD_W   = 32;
    localparam int VAL_W   = 64;
    localparam int HALF_W  = VAL_W / 2;

    // frame stack holds every ancestor of the deepest node
    localparam int STACK_D = $clog2(LEAVES) + 1;
    localparam int SP_W    = $clog2(STACK_D + 1);
    localparam int STK_IW  = $clog2(STACK_D);

    // scaling multiplier widths
    localparam int MUL_LO_W = HALF_W + SPAN_W;
    localparam int MUL_HI_W = HALF_W + SPAN_W + 1;
    localparam int PROD_W   = MUL_HI_W + HALF_W;

    localparam logic [POS_W-1:0] USED_RESET = POS_W'(LEAVES);

    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    // datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_IDLE,
        OP_CLEAR,
        OP_LOAD,
        OP_PD_RD,
        OP_PD_LD,
        OP_PD_MUL,
        OP_PD_SCL,
        OP_PD_SUM,
        OP_DESCEND_L,
        OP_POP,
        OP_GO_RIGHT,
        OP_C_RD_L,
        OP_C_RD_R,
        OP_C_WR,
        OP_Q_STEP,
        OP_Q_ZERO,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   src_w;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic p_zero;
        logic leaf;
        logic disjoint;
        logic covered;
        logic outside;
        logic is_query;
        logic sp_zero;
        logic top_phase;
    } dp_stat_t;

    typedef struct packed {
        logic [SPAN_W-1:0] s;
        logic [SPAN_W-1:0] e;
        logic [SLOT_W-1:0] k;
        logic              phase;
    } frame_t;

    // signed add clamped to the 64-bit limits
    function automatic logic signed [VAL_W-1:0] sat_add(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        logic signed [VAL_W:0] t;
        t = {a[VAL_W-1], a} + {b[VAL_W-1], b};
        if (t[VAL_W] != t[VAL_W-1])
        begin
            sat_add = t[VAL_W] ? VAL_MIN : VAL_MAX;
        end
        else
        begin
            sat_add = t[VAL_W-1:0];
        end
    endfunction

endpackage

@@ rtl/core/lstra_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module lstra_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/lstra_dpath.sv @@
// datapath: node and pending stores, frame stack, saturating scale and add
// depends on lstra_pkg and lstra_ram
module lstra_dpath
    import lstra_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  dp_cmd_t                 cmd,
    output dp_stat_t                stat,
    input  logic                    cfg_we,
    input  logic [POS_W-1:0]        cfg_wdata,
    input  logic                    mode,
    input  logic [POS_W-1:0]        range_low,
    input  logic [POS_W-1:0]        range_high,
    input  logic signed [ADD_W-1:0] add_value,
    input  logic [POS_W-1:0]        query_position,
    output logic signed [VAL_W-1:0] point_value
);

    logic [POS_W-1:0]        used_reg;
    logic [SLOT_W-1:0]       clr_reg;
    logic                    mode_reg;
    logic [POS_W-1:0]        lo_reg;
    logic [POS_W-1:0]        hi_reg;
    logic [POS_W-1:0]        pos_reg;
    logic signed [ADD_W-1:0] w_reg;
    logic [SPAN_W-1:0]       s_reg;
    logic [SPAN_W-1:0]       e_reg;
    logic [SLOT_W-1:0]       k_reg;
    logic [SP_W-1:0]         sp_reg;
    logic signed [VAL_W-1:0] p_reg;
    logic signed [VAL_W-1:0] acc_reg;
    logic signed [VAL_W-1:0] scale_reg;
    logic [MUL_LO_W-1:0]     plo_reg;
    logic signed [MUL_HI_W-1:0] phi_reg;
    logic signed [VAL_W-1:0] point_value_reg;
    frame_t                  stk [STACK_D];

    logic [SPAN_W-1:0]       n_eff;
    logic [SPAN_W:0]         se_sum;
    logic [SPAN_W-1:0]       mid;
    logic [SPAN_W-1:0]       half;
    logic [SPAN_W-1:0]       width;
    logic [SLOT_W-1:0]       lk;
    logic [SLOT_W-1:0]       rk;
    logic [SP_W-1:0]         sp_m1;
    frame_t                  top;
    logic signed [VAL_W-1:0] w_ext;
    logic signed [VAL_W-1:0] p_src;
    logic [PROD_W-1:0]       prod;
    logic [PROD_W-VAL_W:0]   prod_top;
    logic signed [VAL_W-1:0] prod_sat;
    logic                    leaf;

    logic                    pend_we;
    logic [SLOT_W-1:0]       pend_waddr;
    logic [VAL_W-1:0]        pend_wdata;
    logic [SLOT_W-1:0]       pend_raddr;
    logic [VAL_W-1:0]        pend_rdata;
    logic                    sum_we;
    logic [SLOT_W-1:0]       sum_waddr;
    logic [VAL_W-1:0]        sum_wdata;
    logic [SLOT_W-1:0]       sum_raddr;
    logic [VAL_W-1:0]        sum_rdata;

    // effective tree size, clamped to 1..LEAVES
    always_comb
    begin
        if (used_reg == '0)
        begin
            n_eff = SPAN_W'(1);
        end
        else if (used_reg > POS_W'(LEAVES))
        begin
            n_eff = SPAN_W'(LEAVES);
        end
        else
        begin
            n_eff = used_reg;
        end
    end

    // node geometry of the current span
    assign se_sum = {1'b0, s_reg} + {1'b0, e_reg};
    assign mid    = se_sum[SPAN_W:1];
    assign half   = mid - s_reg + SPAN_W'(1);
    assign width  = e_reg - s_reg + SPAN_W'(1);
    assign lk     = k_reg + SLOT_W'(1);
    assign rk     = k_reg + SLOT_W'({half, 1'b0});
    assign leaf   = (s_reg == e_reg);

    // top of the frame stack
    assign sp_m1 = sp_reg - SP_W'(1);
    assign top   = stk[sp_m1[STK_IW-1:0]];

    // pushed amount comes from the store or from the item's add value
    assign w_ext = {{(VAL_W-ADD_W){w_reg[ADD_W-1]}}, w_reg};
    assign p_src = cmd.src_w ? w_ext : $signed(pend_rdata);

    // recombine the split product and clamp it
    assign prod     = {phi_reg, {HALF_W{1'b0}}} + PROD_W'(plo_reg);
    assign prod_top = prod[PROD_W-1:VAL_W-1];
    always_comb
    begin
        if ((&prod_top) || !(|prod_top))
        begin
            prod_sat = prod[VAL_W-1:0];
        end
        else
        begin
            prod_sat = prod[PROD_W-1] ? VAL_MIN : VAL_MAX;
        end
    end

    // status back to the controller
    always_comb
    begin
        stat.clear_last = (clr_reg == SLOT_W'(SLOTS - 1));
        stat.p_zero     = (p_src == '0);
        stat.leaf       = leaf;
        stat.disjoint   = (s_reg > hi_reg) || (e_reg < lo_reg);
        stat.covered    = (s_reg >= lo_reg) && (e_reg <= hi_reg);
        stat.outside    = (s_reg > pos_reg) || (e_reg < pos_reg);
        stat.is_query   = mode_reg;
        stat.sp_zero    = (sp_reg == '0);
        stat.top_phase  = top.phase;
    end

    // pending store port steering
    always_comb
    begin
        pend_we    = 1'b0;
        pend_waddr = k_reg;
        pend_wdata = '0;
        pend_raddr = k_reg;
        unique case (cmd.op)
            OP_CLEAR:
            begin
                pend_we    = 1'b1;
                pend_waddr = clr_reg;
            end
            OP_PD_LD:
            begin
                pend_we    = 1'b1;
                pend_raddr = lk;
            end
            OP_PD_MUL:
            begin
                pend_we    = !leaf;
                pend_waddr = lk;
                pend_wdata = sat_add($signed(pend_rdata), p_reg);
                pend_raddr = rk;
            end
            OP_PD_SCL:
            begin
                pend_we    = !leaf;
                pend_waddr = rk;
                pend_wdata = sat_add($signed(pend_rdata), p_reg);
            end
            default:
            begin
                pend_we = 1'b0;
            end
        endcase
    end

    // node sum store port steering
    always_comb
    begin
        sum_we    = 1'b0;
        sum_waddr = k_reg;
        sum_wdata = '0;
        sum_raddr = k_reg;
        unique case (cmd.op)
            OP_CLEAR:
            begin
                sum_we    = 1'b1;
                sum_waddr = clr_reg;
            end
            OP_PD_SUM:
            begin
                sum_we    = 1'b1;
                sum_wdata = sat_add(acc_reg, scale_reg);
            end
            OP_C_RD_L:
            begin
                sum_raddr = lk;
            end
            OP_C_RD_R:
            begin
                sum_raddr = rk;
            end
            OP_C_WR:
            begin
                sum_we    = 1'b1;
                sum_wdata = sat_add(acc_reg, $signed(sum_rdata));
            end
            default:
            begin
                sum_we = 1'b0;
            end
        endcase
    end

    lstra_ram #(
        .WIDTH(VAL_W),
        .DEPTH(SLOTS)
    ) u_pend_ram (
        .clk   (clk),
        .we    (pend_we),
        .waddr (pend_waddr),
        .wdata (pend_wdata),
        .raddr (pend_raddr),
        .rdata (pend_rdata)
    );

    lstra_ram #(
        .WIDTH(VAL_W),
        .DEPTH(SLOTS)
    ) u_sum_ram (
        .clk   (clk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    // control registers: size, clear sweep, stack pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= USED_RESET;
            clr_reg  <= '0;
            sp_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                used_reg <= cfg_wdata;
            end
            unique case (cmd.op)
                OP_CLEAR:     clr_reg <= clr_reg + SLOT_W'(1);
                OP_LOAD:      sp_reg  <= '0;
                OP_DESCEND_L: sp_reg  <= sp_reg + SP_W'(1);
                OP_POP:
                begin
                    if (top.phase)
                    begin
                        sp_reg <= sp_m1;
                    end
                end
                default:
                begin
                    sp_reg <= sp_reg;
                end
            endcase
        end
    end

    // frame stack contents
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_DESCEND_L)
        begin
            stk[sp_reg[STK_IW-1:0]] <= '{s: s_reg, e: e_reg, k: k_reg, phase: 1'b0};
        end
        else if (cmd.op == OP_POP && !top.phase)
        begin
            stk[sp_m1[STK_IW-1:0]].phase <= 1'b1;
        end
    end

    // item fields, current node and arithmetic registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                mode_reg <= mode;
                lo_reg   <= range_low;
                hi_reg   <= range_high;
                w_reg    <= add_value;
                pos_reg  <= query_position;
                s_reg    <= SPAN_W'(1);
                e_reg    <= n_eff;
                k_reg    <= '0;
            end
            OP_PD_LD:
            begin
                p_reg   <= p_src;
                acc_reg <= $signed(sum_rdata);
            end
            OP_PD_MUL:
            begin
                plo_reg <= p_reg[HALF_W-1:0] * width;
                phi_reg <= $signed(p_reg[VAL_W-1:HALF_W]) * $signed({1'b0, width});
            end
            OP_PD_SCL:
            begin
                scale_reg <= prod_sat;
            end
            OP_PD_SUM:
            begin
                acc_reg <= sat_add(acc_reg, scale_reg);
            end
            OP_DESCEND_L:
            begin
                e_reg <= mid;
                k_reg <= lk;
            end
            OP_POP:
            begin
                s_reg <= top.s;
                e_reg <= top.e;
                k_reg <= top.k;
            end
            OP_GO_RIGHT:
            begin
                s_reg <= mid + SPAN_W'(1);
                k_reg <= rk;
            end
            OP_C_RD_R:
            begin
                acc_reg <= $signed(sum_rdata);
            end
            OP_Q_STEP:
            begin
                if (pos_reg <= mid)
                begin
                    e_reg <= mid;
                    k_reg <= lk;
                end
                else
                begin
                    s_reg <= mid + SPAN_W'(1);
                    k_reg <= rk;
                end
            end
            OP_Q_ZERO:
            begin
                acc_reg <= '0;
            end
            OP_OUT:
            begin
                point_value_reg <= acc_reg;
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign point_value = point_value_reg;

endmodule

@@ rtl/core/lstra_ctrl.sv @@
// controller: sequences clearing, tree walks, lazy pushes and the result transfer
// depends on lstra_pkg
module lstra_ctrl
    import lstra_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [13:0] {
        ST_CLEAR  = 14'b00000000000001,
        ST_IDLE   = 14'b00000000000010,
        ST_VISIT  = 14'b00000000000100,
        ST_PD_LD  = 14'b00000000001000,
        ST_PD_MUL = 14'b00000000010000,
        ST_PD_SCL = 14'b00000000100000,
        ST_PD_SUM = 14'b00000001000000,
        ST_POST   = 14'b00000010000000,
        ST_RET    = 14'b00000100000000,
        ST_RIGHT  = 14'b00001000000000,
        ST_C_L    = 14'b00010000000000,
        ST_C_R    = 14'b00100000000000,
        ST_C_WR   = 14'b01000000000000,
        ST_RESULT = 14'b10000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   second_reg;
    logic   second_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   can_load;

    assign can_load = !out_valid_reg || !out_stall;

    // next state and datapath command
    always_comb
    begin
        state_next  = state_reg;
        second_next = second_reg;
        cmd.op      = OP_IDLE;
        cmd.src_w   = second_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.op = OP_CLEAR;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op      = OP_LOAD;
                    second_next = 1'b0;
                    state_next  = ST_VISIT;
                end
            end
            ST_VISIT:
            begin
                cmd.op     = OP_PD_RD;
                state_next = ST_PD_LD;
            end
            ST_PD_LD:
            begin
                cmd.op     = OP_PD_LD;
                state_next = stat.p_zero ? ST_POST : ST_PD_MUL;
            end
            ST_PD_MUL:
            begin
                cmd.op     = OP_PD_MUL;
                state_next = ST_PD_SCL;
            end
            ST_PD_SCL:
            begin
                cmd.op     = OP_PD_SCL;
                state_next = ST_PD_SUM;
            end
            ST_PD_SUM:
            begin
                cmd.op     = OP_PD_SUM;
                state_next = ST_POST;
            end
            ST_POST:
            begin
                // decide where the walk goes after the node is up to date
                if (stat.is_query)
                begin
                    if (stat.outside)
                    begin
                        cmd.op     = OP_Q_ZERO;
                        state_next = ST_RESULT;
                    end
                    else if (stat.leaf)
                    begin
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        cmd.op     = OP_Q_STEP;
                        state_next = ST_VISIT;
                    end
                end
                else if (second_reg || stat.disjoint)
                begin
                    state_next = ST_RET;
                end
                else if (stat.covered)
                begin
                    second_next = 1'b1;
                    state_next  = ST_VISIT;
                end
                else
                begin
                    cmd.op      = OP_DESCEND_L;
                    second_next = 1'b0;
                    state_next  = ST_VISIT;
                end
            end
            ST_RET:
            begin
                if (stat.sp_zero)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.op     = OP_POP;
                    state_next = stat.top_phase ? ST_C_L : ST_RIGHT;
                end
            end
            ST_RIGHT:
            begin
                cmd.op      = OP_GO_RIGHT;
                second_next = 1'b0;
                state_next  = ST_VISIT;
            end
            ST_C_L:
            begin
                cmd.op     = OP_C_RD_L;
                state_next = ST_C_R;
            end
            ST_C_R:
            begin
                cmd.op     = OP_C_RD_R;
                state_next = ST_C_WR;
            end
            ST_C_WR:
            begin
                cmd.op     = OP_C_WR;
                state_next = ST_RET;
            end
            ST_RESULT:
            begin
                if (can_load)
                begin
                    cmd.op     = OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid: set on a new result, cleared on transfer
    always_comb
    begin
        if (state_reg == ST_RESULT && can_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            second_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            second_reg    <= second_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

@@ rtl/core/lazy_segment_tree_range_add.sv @@
// top level of the lazy segment tree with range add and point query
// depends on lstra_pkg, lstra_ctrl and lstra_dpath
//
// After reset the block sweeps both 2048-entry stores to zero, one slot a
// cycle, and holds in_stall high meanwhile; used_size may be written during
// the sweep. Items are then taken one at a time. Each visited node is read
// and loaded; a node that carries a pending amount then adds it to both
// children's pending entries and, scaled by the node's width through a
// multiplier split into 32-bit halves, to its own sum. A range add also
// steps over to the right child of each internal node and recombines both
// children on the way back up. A query takes one node per tree level (about
// 11 levels at 1024 positions); a range add visits up to about four nodes
// per level. A finished result waits in the output register while the next
// item is taken.
module lazy_segment_tree_range_add
    import lstra_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [POS_W-1:0]        cfg_wdata,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    mode,
    input  logic [POS_W-1:0]        range_low,
    input  logic [POS_W-1:0]        range_high,
    input  logic signed [ADD_W-1:0] add_value,
    input  logic [POS_W-1:0]        query_position,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [VAL_W-1:0] point_value
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // controller
    lstra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath
    lstra_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .mode           (mode),
        .range_low      (range_low),
        .range_high     (range_high),
        .add_value      (add_value),
        .query_position (query_position),
        .point_value    (point_value)
    );

endmodule

@@ rtl/core/lstra_checker.sv @@
// port-level checks for the lazy segment tree, bound to the top level
// depends on lstra_pkg
module lstra_checker
    import lstra_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    cfg_we,
    input logic [POS_W-1:0]        cfg_wdata,
    input logic                    in_valid,
    input logic                    in_stall,
    input logic                    mode,
    input logic [POS_W-1:0]        range_low,
    input logic [POS_W-1:0]        range_high,
    input logic signed [ADD_W-1:0] add_value,
    input logic [POS_W-1:0]        query_position,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic signed [VAL_W-1:0] point_value
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(point_value))
    else $error("stalled result changed");

    // the block is busy right after taking an item
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
    else $error("input taken twice in a row");

    // store clearing holds off input right after reset
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> in_stall)
    else $error("input open during clearing");

endmodule

bind lazy_segment_tree_range_add lstra_checker u_lstra_checker (.*);
